[src/serial_mouse_packet_encoder_top_defines.svh]
// Assertion macros for the serial mouse packet encoder.
`ifndef SERIAL_MOUSE_PACKET_ENCODER_TOP_DEFINES_SVH
`define SERIAL_MOUSE_PACKET_ENCODER_TOP_DEFINES_SVH

// Check that a condition holds on every clock out of reset.
`define SMPE_ASSERT_HOLDS(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("smpe invariant violated");

// Check that a consequent holds in the same cycle as its antecedent.
`define SMPE_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpe implication violated");

`endif

[src/smpe_pkg.sv]
// Shared constants, types and ID string tables for the serial mouse packet encoder.
package smpe_pkg;

    localparam int ACC_WIDTH   = 16;
    localparam int TIME_WIDTH  = 21;
    localparam int SENS_W      = 16;
    localparam int INTERVAL_W  = 20;
    localparam int CFG_DATA_W  = 20;
    localparam int PROD_W      = ACC_WIDTH + SENS_W;
    localparam int CMP_W       = ((TIME_WIDTH > INTERVAL_W + 1) ? TIME_WIDTH : INTERVAL_W + 1) + 1;
    localparam int ID_CURSOR_W = 7;
    localparam int PKT_BYTES   = 5;
    localparam int PKT_LEN_W   = 3;

    // Input item kinds
    localparam logic [1:0] FUNC_HID   = 2'd0;
    localparam logic [1:0] FUNC_MODEM = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_PULL  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_PROTOCOL    = 2'd0;
    localparam logic [1:0] REG_SENSITIVITY = 2'd1;
    localparam logic [1:0] REG_INTERVAL    = 2'd2;
    localparam logic [1:0] REG_ENABLED     = 2'd3;

    // Protocol selections
    localparam logic [1:0] PROTO_TWO   = 2'd0;
    localparam logic [1:0] PROTO_THREE = 2'd1;
    localparam logic [1:0] PROTO_WHEEL = 2'd2;
    localparam logic [1:0] PROTO_FIVE  = 2'd3;

    // Packet field constants
    localparam logic [7:0] PKT_SYNC     = 8'h40;
    localparam logic [7:0] PKT_LEFT     = 8'h20;
    localparam logic [7:0] PKT_RIGHT    = 8'h10;
    localparam logic [7:0] PKT_LOW6     = 8'h3F;
    localparam logic [7:0] PKT_MIDDLE   = 8'h20;
    localparam logic [7:0] PKT_WHL_MID  = 8'h10;
    localparam logic [7:0] PKT5_SYNC    = 8'h80;

    localparam logic signed [PROD_W-1:0] Q_HI = PROD_W'(127);
    localparam logic signed [PROD_W-1:0] Q_LO = -Q_HI;

    localparam logic [ID_CURSOR_W-1:0] ID_TWO_LEN   = 7'd1;
    localparam logic [ID_CURSOR_W-1:0] ID_THREE_LEN = 7'd2;
    localparam logic [ID_CURSOR_W-1:0] ID_WHEEL_LEN = 7'd82;
    localparam logic [ID_CURSOR_W-1:0] ID_FIVE_LEN  = 7'd5;

    localparam logic [7:0] ID_PLAIN = 8'h4D;
    localparam logic [7:0] ID_MID   = 8'h33;
    localparam logic [7:0] ID_FIVE  = 8'h87;

    localparam logic [7:0] ID_WHEEL [0:81] = '{
        8'h4D, 8'h5A, 8'h40, 8'h00, 8'h00, 8'h00,
        8'h08, 8'h01, 8'h24, 8'h2D, 8'h33, 8'h28, 8'h10, 8'h10,
        8'h10, 8'h11, 8'h3C, 8'h10, 8'h10, 8'h10, 8'h14, 8'h10,
        8'h12, 8'h10, 8'h10, 8'h3C, 8'h2D, 8'h2F, 8'h35, 8'h33,
        8'h25, 8'h3C, 8'h30, 8'h2E, 8'h30, 8'h10, 8'h26, 8'h10,
        8'h21, 8'h3C, 8'h2D, 8'h29, 8'h23, 8'h32, 8'h2F, 8'h33,
        8'h2F, 8'h26, 8'h34, 8'h00, 8'h29, 8'h2E, 8'h34, 8'h25,
        8'h2C, 8'h2C, 8'h29, 8'h2D, 8'h2F, 8'h35, 8'h33, 8'h25,
        8'h00, 8'h0D, 8'h00, 8'h33, 8'h25, 8'h32, 8'h29, 8'h21,
        8'h2C, 8'h00, 8'h36, 8'h25, 8'h32, 8'h33, 8'h29, 8'h2F,
        8'h2E, 8'h15, 8'h16, 8'h09
    };

    typedef struct packed {
        logic                        changed;
        logic [PKT_LEN_W-1:0]        length;
        logic [PKT_BYTES-1:0][7:0]   bytes;
    } pkt_t;

    function automatic logic [ID_CURSOR_W-1:0] id_len(input logic [1:0] proto);
        logic [ID_CURSOR_W-1:0] len;
        case (proto)
            PROTO_TWO:   len = ID_TWO_LEN;
            PROTO_THREE: len = ID_THREE_LEN;
            PROTO_WHEEL: len = ID_WHEEL_LEN;
            default:     len = ID_FIVE_LEN;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] id_byte(input logic [1:0] proto,
                                           input logic [ID_CURSOR_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (proto)
            PROTO_TWO:
                if (idx == '0) b = ID_PLAIN;
            PROTO_THREE:
                if (idx == '0) b = ID_PLAIN;
                else if (idx == ID_CURSOR_W'(1)) b = ID_MID;
            PROTO_WHEEL:
                if (idx < ID_WHEEL_LEN) b = ID_WHEEL[idx];
            default:
                if (idx == '0) b = ID_FIVE;
        endcase
        return b;
    endfunction

endpackage

[src/smpe_packet_builder.sv]
// Scales the X and Y motion accumulators and formats the report packet for the selected protocol.
module smpe_packet_builder (
    input  logic [1:0]                              protocol,
    input  logic signed [smpe_pkg::SENS_W-1:0]      sensitivity,
    input  logic signed [smpe_pkg::ACC_WIDTH-1:0]   acc_x,
    input  logic signed [smpe_pkg::ACC_WIDTH-1:0]   acc_y,
    input  logic signed [smpe_pkg::ACC_WIDTH-1:0]   acc_z,
    input  logic [2:0]                              btn_now,
    input  logic [2:0]                              btn_sent,
    output smpe_pkg::pkt_t                          pkt
);

    logic signed [smpe_pkg::PROD_W-1:0] prod_x;
    logic signed [smpe_pkg::PROD_W-1:0] prod_y;
    logic signed [smpe_pkg::PROD_W-1:0] q_x;
    logic signed [smpe_pkg::PROD_W-1:0] q_y;
    logic [7:0] x;
    logic [7:0] y;
    logic [2:0] btn_any;

    // Arithmetic shift gives the floor of the Q24.8 product.
    assign prod_x = acc_x * sensitivity;
    assign prod_y = acc_y * sensitivity;
    assign q_x    = prod_x >>> 8;
    assign q_y    = prod_y >>> 8;

    always_comb
    begin
        if (q_x > smpe_pkg::Q_HI)
            x = smpe_pkg::Q_HI[7:0];
        else if (q_x < smpe_pkg::Q_LO)
            x = smpe_pkg::Q_LO[7:0];
        else
            x = q_x[7:0];

        if (q_y > smpe_pkg::Q_HI)
            y = smpe_pkg::Q_HI[7:0];
        else if (q_y < smpe_pkg::Q_LO)
            y = smpe_pkg::Q_LO[7:0];
        else
            y = q_y[7:0];
    end

    assign btn_any = btn_now | btn_sent;

    always_comb
    begin
        pkt.changed = (acc_x != '0) || (acc_y != '0) || (acc_z != '0) || (btn_now != btn_sent);
        pkt.bytes   = '0;
        pkt.length  = smpe_pkg::PKT_LEN_W'(3);
        if (protocol == smpe_pkg::PROTO_FIVE)
        begin
            // Buttons are active low in this format.
            pkt.bytes[0] = smpe_pkg::PKT5_SYNC | {5'b0, ~btn_now[0], ~btn_now[2], ~btn_now[1]};
            pkt.bytes[1] = x;
            pkt.bytes[2] = 8'(8'd0 - y);
            pkt.length   = smpe_pkg::PKT_LEN_W'(5);
        end
        else
        begin
            pkt.bytes[0] = smpe_pkg::PKT_SYNC
                         | (btn_now[0] ? smpe_pkg::PKT_LEFT : 8'h00)
                         | (btn_now[1] ? smpe_pkg::PKT_RIGHT : 8'h00)
                         | {4'b0, y[7:6], 2'b0}
                         | {6'b0, x[7:6]};
            pkt.bytes[1] = x & smpe_pkg::PKT_LOW6;
            pkt.bytes[2] = y & smpe_pkg::PKT_LOW6;
            if (protocol == smpe_pkg::PROTO_WHEEL)
            begin
                pkt.bytes[3] = {3'b0, btn_now[2], 4'(4'd0 - acc_z[3:0])};
                pkt.length   = smpe_pkg::PKT_LEN_W'(4);
            end
            else if (protocol == smpe_pkg::PROTO_THREE && btn_any[2])
            begin
                pkt.bytes[3] = btn_now[2] ? smpe_pkg::PKT_MIDDLE : 8'h00;
                pkt.length   = smpe_pkg::PKT_LEN_W'(4);
            end
        end
    end

endmodule

[src/serial_mouse_packet_encoder_top.sv]
// Serial mouse packet encoder top level: input stage, mouse state, result stage.
// The block takes one item per clock unless in_stall is raised, and returns exactly
// one result beat per item, through the input register and then the result register. Items
// are registered, then the state update (saturating accumulators, mode sequencing,
// report grid, packet build) runs combinationally into the result register; the clock
// is bounded by the two 16x16 sensitivity multipliers and clamp in the packet builder.
// A stalled result register holds the input register, which then stalls the input.
// Configuration writes are taken every cycle and must arrive only while the block is idle.
`include "serial_mouse_packet_encoder_top_defines.svh"

module serial_mouse_packet_encoder_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            func,
    input  logic signed [7:0]                     dx,
    input  logic signed [7:0]                     dy,
    input  logic signed [7:0]                     wheel,
    input  logic [2:0]                            buttons,
    input  logic [1:0]                            modem_bits,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  byte_valid,
    output logic [7:0]                            data_byte,
    output logic                                  dsr,
    output logic [1:0]                            mouse_mode,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [smpe_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        MODE_RESET = 2'd0,
        MODE_ID    = 2'd1,
        MODE_RUN   = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Configuration
    logic [1:0]                               protocol_reg;
    logic signed [smpe_pkg::SENS_W-1:0]       sens_reg;
    logic [smpe_pkg::INTERVAL_W-1:0]          interval_reg;
    logic                                     enabled_reg;

    // Input stage
    logic                                     s1_valid_reg;
    logic                                     s1_valid_next;
    logic [1:0]                               s1_func_reg;
    logic signed [7:0]                        s1_dx_reg;
    logic signed [7:0]                        s1_dy_reg;
    logic signed [7:0]                        s1_wheel_reg;
    logic [2:0]                               s1_buttons_reg;
    logic [1:0]                               s1_modem_reg;

    // Mouse state
    mode_t                                    mode_reg, mode_next, mode_eff;
    mode_t                                    pend_reg, pend_next;
    logic                                     last_rts_reg, last_rts_next;
    logic                                     dsr_reg, dsr_next;
    logic signed [smpe_pkg::ACC_WIDTH-1:0]    acc_x_reg, acc_x_next;
    logic signed [smpe_pkg::ACC_WIDTH-1:0]    acc_y_reg, acc_y_next;
    logic signed [smpe_pkg::ACC_WIDTH-1:0]    acc_z_reg, acc_z_next;
    logic [2:0]                               btn_now_reg, btn_now_next;
    logic [2:0]                               btn_sent_reg, btn_sent_next;
    logic [smpe_pkg::TIME_WIDTH-1:0]          elapsed_reg, elapsed_next, elapsed_inc;
    logic [smpe_pkg::CMP_W-1:0]               elapsed_ext, iv_ext, iv2_ext;
    logic [smpe_pkg::ID_CURSOR_W-1:0]         id_cursor_reg, id_cursor_next, cur_eff;
    logic [smpe_pkg::PKT_BYTES-1:0][7:0]      pkt_bytes_reg;
    logic                                     pkt_wr;
    logic [smpe_pkg::PKT_LEN_W-1:0]           pkt_len_reg, pkt_len_next;
    logic [smpe_pkg::PKT_LEN_W-1:0]           pkt_cursor_reg, pkt_cursor_next;
    smpe_pkg::pkt_t                           pkt;

    // Result stage
    logic                                     out_valid_reg, out_valid_next;
    logic                                     advance;
    logic                                     res_valid;
    logic [7:0]                               res_data;
    logic                                     byte_valid_reg;
    logic [7:0]                               data_byte_reg;
    logic                                     dsr_out_reg;
    logic [1:0]                               mode_out_reg;

    function automatic logic signed [smpe_pkg::ACC_WIDTH-1:0] sat_add(
        input logic signed [smpe_pkg::ACC_WIDTH-1:0] a,
        input logic signed [7:0]                     d
    );
        logic signed [smpe_pkg::ACC_WIDTH:0] s;
        logic signed [smpe_pkg::ACC_WIDTH-1:0] r;
        s = (smpe_pkg::ACC_WIDTH+1)'(a) + (smpe_pkg::ACC_WIDTH+1)'(d);
        if (s[smpe_pkg::ACC_WIDTH] != s[smpe_pkg::ACC_WIDTH-1])
            r = {s[smpe_pkg::ACC_WIDTH], {(smpe_pkg::ACC_WIDTH-1){~s[smpe_pkg::ACC_WIDTH]}}};
        else
            r = s[smpe_pkg::ACC_WIDTH-1:0];
        return r;
    endfunction

    smpe_packet_builder u_builder (
        .protocol    (protocol_reg),
        .sensitivity (sens_reg),
        .acc_x       (acc_x_reg),
        .acc_y       (acc_y_reg),
        .acc_z       (acc_z_reg),
        .btn_now     (btn_now_reg),
        .btn_sent    (btn_sent_reg),
        .pkt         (pkt)
    );

    // Handshake: a beat leaves the input stage when the result register is free.
    assign advance        = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s1_valid_reg && !advance;
    assign s1_valid_next  = in_stall ? s1_valid_reg : in_valid;
    assign out_valid_next = advance ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    assign cfg_ready      = 1'b1;

    assign out_valid  = out_valid_reg;
    assign byte_valid = byte_valid_reg;
    assign data_byte  = data_byte_reg;
    assign dsr        = dsr_out_reg;
    assign mouse_mode = mode_out_reg;

    // Report grid arithmetic
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : smpe_pkg::TIME_WIDTH'(elapsed_reg + 1'b1);
    assign elapsed_ext = smpe_pkg::CMP_W'(elapsed_inc);
    assign iv_ext      = smpe_pkg::CMP_W'(interval_reg);
    assign iv2_ext     = smpe_pkg::CMP_W'({interval_reg, 1'b0});

    always_comb
    begin
        mode_next       = mode_reg;
        pend_next       = pend_reg;
        last_rts_next   = last_rts_reg;
        dsr_next        = dsr_reg;
        acc_x_next      = acc_x_reg;
        acc_y_next      = acc_y_reg;
        acc_z_next      = acc_z_reg;
        btn_now_next    = btn_now_reg;
        btn_sent_next   = btn_sent_reg;
        elapsed_next    = elapsed_reg;
        id_cursor_next  = id_cursor_reg;
        pkt_len_next    = pkt_len_reg;
        pkt_cursor_next = pkt_cursor_reg;
        pkt_wr          = 1'b0;
        res_valid       = 1'b0;
        res_data        = 8'h00;
        mode_eff        = mode_reg;
        cur_eff         = id_cursor_reg;

        if (advance)
        begin
            unique case (s1_func_reg)
                smpe_pkg::FUNC_HID:
                begin
                    if (enabled_reg && mode_reg == MODE_RUN)
                    begin
                        acc_x_next   = sat_add(acc_x_reg, s1_dx_reg);
                        acc_y_next   = sat_add(acc_y_reg, s1_dy_reg);
                        acc_z_next   = sat_add(acc_z_reg, s1_wheel_reg);
                        btn_now_next = s1_buttons_reg;
                    end
                end
                smpe_pkg::FUNC_MODEM:
                begin
                    dsr_next      = s1_modem_reg[0];
                    last_rts_next = s1_modem_reg[1];
                    if (s1_modem_reg[1] != last_rts_reg)
                        pend_next = s1_modem_reg[1] ? MODE_ID : MODE_RESET;
                end
                smpe_pkg::FUNC_TICK:
                begin
                    // Apply the scheduled mode first.
                    if (pend_reg != MODE_NONE)
                    begin
                        if (pend_reg == MODE_ID)
                        begin
                            cur_eff         = '0;
                            pkt_len_next    = '0;
                            pkt_cursor_next = '0;
                        end
                        mode_eff  = pend_reg;
                        pend_next = MODE_NONE;
                    end
                    mode_next      = mode_eff;
                    id_cursor_next = cur_eff;
                    if (mode_eff == MODE_ID)
                    begin
                        if (cur_eff >= smpe_pkg::id_len(protocol_reg))
                        begin
                            mode_next    = MODE_RUN;
                            elapsed_next = '0;
                        end
                    end
                    else if (mode_eff == MODE_RUN)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_ext >= iv_ext)
                        begin
                            // Restart the grid when a slot is late by a whole interval.
                            if (elapsed_ext >= iv2_ext)
                                elapsed_next = '0;
                            else
                                elapsed_next = smpe_pkg::TIME_WIDTH'(elapsed_ext - iv_ext);
                            if (pkt.changed)
                            begin
                                pkt_wr          = 1'b1;
                                pkt_len_next    = pkt.length;
                                pkt_cursor_next = '0;
                                acc_x_next      = '0;
                                acc_y_next      = '0;
                                acc_z_next      = '0;
                                btn_sent_next   = btn_now_reg;
                            end
                        end
                    end
                end
                smpe_pkg::FUNC_PULL:
                begin
                    if (mode_reg == MODE_ID)
                    begin
                        if (id_cursor_reg < smpe_pkg::id_len(protocol_reg))
                        begin
                            res_valid      = 1'b1;
                            res_data       = smpe_pkg::id_byte(protocol_reg, id_cursor_reg);
                            id_cursor_next = smpe_pkg::ID_CURSOR_W'(id_cursor_reg + 1'b1);
                        end
                    end
                    else if (pkt_cursor_reg < pkt_len_reg &&
                             pkt_cursor_reg < smpe_pkg::PKT_LEN_W'(smpe_pkg::PKT_BYTES))
                    begin
                        res_valid       = 1'b1;
                        res_data        = pkt_bytes_reg[pkt_cursor_reg];
                        pkt_cursor_next = smpe_pkg::PKT_LEN_W'(pkt_cursor_reg + 1'b1);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_reg <= smpe_pkg::PROTO_TWO;
            sens_reg     <= smpe_pkg::SENS_W'(256);
            interval_reg <= smpe_pkg::INTERVAL_W'(25000);
            enabled_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                smpe_pkg::REG_PROTOCOL:    protocol_reg <= cfg_data[1:0];
                smpe_pkg::REG_SENSITIVITY: sens_reg     <= cfg_data[smpe_pkg::SENS_W-1:0];
                smpe_pkg::REG_INTERVAL:    interval_reg <= cfg_data[smpe_pkg::INTERVAL_W-1:0];
                smpe_pkg::REG_ENABLED:     enabled_reg  <= cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= MODE_RESET;
            pend_reg       <= MODE_RESET;
            last_rts_reg   <= 1'b0;
            dsr_reg        <= 1'b0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_z_reg      <= '0;
            btn_now_reg    <= '0;
            btn_sent_reg   <= '0;
            elapsed_reg    <= '0;
            id_cursor_reg  <= '0;
            pkt_len_reg    <= '0;
            pkt_cursor_reg <= '0;
            byte_valid_reg <= 1'b0;
            data_byte_reg  <= 8'h00;
            dsr_out_reg    <= 1'b0;
            mode_out_reg   <= MODE_RESET;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            mode_reg       <= mode_next;
            pend_reg       <= pend_next;
            last_rts_reg   <= last_rts_next;
            dsr_reg        <= dsr_next;
            acc_x_reg      <= acc_x_next;
            acc_y_reg      <= acc_y_next;
            acc_z_reg      <= acc_z_next;
            btn_now_reg    <= btn_now_next;
            btn_sent_reg   <= btn_sent_next;
            elapsed_reg    <= elapsed_next;
            id_cursor_reg  <= id_cursor_next;
            pkt_len_reg    <= pkt_len_next;
            pkt_cursor_reg <= pkt_cursor_next;
            if (advance)
            begin
                byte_valid_reg <= res_valid;
                data_byte_reg  <= res_data;
                dsr_out_reg    <= dsr_next;
                mode_out_reg   <= mode_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            s1_func_reg    <= func;
            s1_dx_reg      <= dx;
            s1_dy_reg      <= dy;
            s1_wheel_reg   <= wheel;
            s1_buttons_reg <= buttons;
            s1_modem_reg   <= modem_bits;
        end
        if (pkt_wr)
            pkt_bytes_reg <= pkt.bytes;
    end

    `SMPE_ASSERT_IMPLIES(a_empty_beat_zero, out_valid && !byte_valid, data_byte == 8'h00)
    `SMPE_ASSERT_HOLDS(a_pkt_cursor_bound, pkt_cursor_reg <= pkt_len_reg)
    `SMPE_ASSERT_IMPLIES(a_stall_when_full, in_stall, s1_valid_reg && out_valid_reg && out_stall)
    `SMPE_ASSERT_HOLDS(a_id_cursor_bound, id_cursor_reg <= smpe_pkg::ID_WHEEL_LEN)

endmodule
